>>> src/adcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adcsd_pkg;

    localparam int SAMPLE_W = 10;
    localparam int HEIGHT_W = 8;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 2;
    localparam int DIFF_W   = SAMPLE_W + 2;
    localparam int INV_W    = SAMPLE_W + 1;
    localparam int PROD_W   = INV_W + HEIGHT_W;

    localparam logic signed [DIFF_W-1:0] LPF_ROUND     = DIFF_W'(4);
    localparam int                       LPF_SHIFT     = 3;
    localparam int                       POS_SHIFT     = 10;
    localparam logic [HEIGHT_W-1:0]      POS_MARGIN    = HEIGHT_W'(2);
    localparam logic [COUNT_W-1:0]       DEBOUNCE_LAST = COUNT_W'(3);
    localparam logic [HEIGHT_W-1:0]      HEIGHT_RESET  = HEIGHT_W'(16);
    localparam logic [SAMPLE_W-1:0]      SAMPLE_MAX    = '1;
    localparam logic [INV_W-1:0]         FULL_SCALE    = INV_W'(1024);

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                fire;
    } front_t;

endpackage
`default_nettype wire

>>> src/adcsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface adcsd_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] adc_sample;
    logic       button_level;

    modport source (output valid, output adc_sample, output button_level, input ready);
    modport sink (input valid, input adc_sample, input button_level, output ready);
endinterface

interface adcsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] position;
    logic       position_changed;
    logic       fire;

    modport source (output valid, output position, output position_changed, output fire,
                    input ready);
    modport sink (input valid, input position, input position_changed, input fire,
                  output ready);
endinterface

interface adcsd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] screen_height;

    modport source (output valid, output screen_height, input ready);
    modport sink (input valid, input screen_height, output ready);
endinterface
`default_nettype wire

>>> src/adcsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module adcsd_front
    import adcsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    adcsd_in_if.sink    sample_ch,
    output front_t      front_data,
    output logic        front_valid,
    input  wire logic   front_ready
);

    logic                       take;
    logic                       front_valid_reg;
    front_t                     front_data_reg;
    front_t                     front_data_next;
    logic [SAMPLE_W-1:0]        filtered_reg;
    logic [SAMPLE_W-1:0]        filtered_next;
    logic                       stable_button_reg;
    logic                       stable_button_next;
    logic [COUNT_W-1:0]         debounce_count_reg;
    logic [COUNT_W-1:0]         debounce_count_next;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   step;
    logic signed [DIFF_W-1:0]   sum;
    logic                       fire_next;

    assign sample_ch.ready = !front_valid_reg || front_ready;
    assign take            = sample_ch.valid && sample_ch.ready;
    assign front_valid     = front_valid_reg;
    assign front_data      = front_data_reg;

    // low-pass filter with rounding, floor shift
    always_comb
    begin
        diff = $signed({2'b00, sample_ch.adc_sample}) - $signed({2'b00, filtered_reg})
               + LPF_ROUND;
        step = diff >>> LPF_SHIFT;
        sum  = $signed({2'b00, filtered_reg}) + step;
        if (sum < 0)
        begin
            filtered_next = '0;
        end
        else if (sum > $signed({2'b00, SAMPLE_MAX}))
        begin
            filtered_next = SAMPLE_MAX;
        end
        else
        begin
            filtered_next = sum[SAMPLE_W-1:0];
        end
    end

    // debounce counter
    always_comb
    begin
        stable_button_next  = stable_button_reg;
        debounce_count_next = '0;
        fire_next           = 1'b0;
        if (debounce_count_reg == DEBOUNCE_LAST)
        begin
            if (sample_ch.button_level != stable_button_reg)
            begin
                stable_button_next = sample_ch.button_level;
                fire_next          = !sample_ch.button_level;
            end
        end
        else if (sample_ch.button_level != stable_button_reg)
        begin
            debounce_count_next = debounce_count_reg + COUNT_W'(1);
        end
        front_data_next.filtered = filtered_next;
        front_data_next.fire     = fire_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg    <= 1'b0;
            filtered_reg       <= '0;
            stable_button_reg  <= 1'b0;
            debounce_count_reg <= '0;
        end
        else
        begin
            if (sample_ch.ready)
            begin
                front_valid_reg <= sample_ch.valid;
            end
            if (take)
            begin
                filtered_reg       <= filtered_next;
                stable_button_reg  <= stable_button_next;
                debounce_count_reg <= debounce_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_data_reg <= front_data_next;
        end
    end

    a_fire_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (take && fire_next) |=> !stable_button_reg)
        else $error("fire without debounced press");

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && debounce_count_reg == DEBOUNCE_LAST) |=> debounce_count_reg == '0)
        else $error("debounce count did not clear");

    a_stable_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stable_button_reg) |-> $past(take && debounce_count_reg == DEBOUNCE_LAST))
        else $error("debounced level changed early");

endmodule
`default_nettype wire

>>> src/adcsd_scale.sv
`timescale 1ns / 1ps
`default_nettype none
module adcsd_scale
    import adcsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    adcsd_cfg_if.sink   cfg,
    input  wire front_t front_data,
    input  wire logic   front_valid,
    output logic        front_ready,
    adcsd_out_if.source result_ch
);

    logic                load;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] scale;
    logic [INV_W-1:0]    inv;
    logic [PROD_W-1:0]   prod;
    logic [POS_W-1:0]    position_next;
    logic                result_valid_reg;
    logic [POS_W-1:0]    position_reg;
    logic                changed_reg;
    logic                fire_reg;

    assign cfg.ready   = 1'b1;
    assign front_ready = !result_valid_reg || result_ch.ready;
    assign load        = front_valid && front_ready;

    assign scale         = (height_reg >= POS_MARGIN) ? (height_reg - POS_MARGIN) : '0;
    assign inv           = FULL_SCALE - {1'b0, front_data.filtered};
    assign prod          = PROD_W'(inv) * PROD_W'(scale);
    assign position_next = prod[POS_SHIFT +: POS_W];

    assign result_ch.valid            = result_valid_reg;
    assign result_ch.position         = position_reg;
    assign result_ch.position_changed = changed_reg;
    assign result_ch.fire             = fire_reg;

    // position_reg doubles as the last reported position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg       <= HEIGHT_RESET;
            result_valid_reg <= 1'b0;
            position_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                height_reg <= cfg.screen_height;
            end
            if (front_ready)
            begin
                result_valid_reg <= front_valid;
            end
            if (load)
            begin
                position_reg <= position_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            changed_reg <= (position_next != position_reg);
            fire_reg    <= front_data.fire;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> position_next <= scale)
        else $error("position beyond scale");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid_reg)
        else $error("loaded beat not shown");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |-> (result_valid_reg && !result_ch.ready))
        else $error("stall without full output");

endmodule
`default_nettype wire

>>> src/adc_smoothing_and_button_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// ADC smoothing and button debounce. Each beat on sample_ch carries one 10-bit
// converter sample and one raw button level (0 = pressed) and yields exactly one beat
// on result_ch: the filtered position (first-order low-pass with rounding, inverted
// and scaled by screen_height - 2), a flag when that position differs from the
// previous one, and a fire pulse when the four-sample debounced level becomes
// pressed. The block takes one beat every cycle while result_ch is ready; each result
// is registered first in the filter and debounce stage and then in the scaling
// multiply stage. Write screen_height on cfg only while no beat is in flight.
module adc_smoothing_and_button_debounce
    import adcsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    adcsd_cfg_if.sink   cfg,
    adcsd_in_if.sink    sample_ch,
    adcsd_out_if.source result_ch
);

    front_t front_data;
    logic   front_valid;
    logic   front_ready;

    adcsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .front_data  (front_data),
        .front_valid (front_valid),
        .front_ready (front_ready)
    );

    adcsd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .front_data  (front_data),
        .front_valid (front_valid),
        .front_ready (front_ready),
        .result_ch   (result_ch)
    );

endmodule
`default_nettype wire
